FILE: hdl/mclr_pkg.sv
`default_nettype none

package mclr_pkg;

    // Field widths of the request, the result and the settings
    localparam int unsigned CountW  = 16;
    localparam int unsigned SampleW = 10;
    localparam int unsigned DirW    = 2;
    localparam int unsigned DutyW   = 8;
    localparam int unsigned DriveW  = 9;
    localparam int unsigned CfgIdxW = 2;

    // Direction codes
    localparam logic [DirW-1:0] DIR_REVERSE = 2'd0;
    localparam logic [DirW-1:0] DIR_FORWARD = 2'd1;
    localparam logic [DirW-1:0] DIR_BRAKE   = 2'd2;

    // Settings register indexes
    localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_TICKS   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_PERIOD_TICKS    = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_SPIKE_ALLOWANCE = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_CURRENT_LIMIT   = 2'd3;

    // Settings reset values
    localparam logic [CountW-1:0]  TIMEOUT_RESET  = 16'd122;
    localparam logic [CountW-1:0]  PERIOD_RESET   = 16'd250;
    localparam logic [CountW-1:0]  OVERSPK_RESET  = 16'd50;
    localparam logic [SampleW-1:0] LIMIT_RESET    = 10'd200;

    // Ceiling limits of the two ramps
    localparam logic [DutyW-1:0] CEIL_FLOOR = 8'd128;
    localparam logic [DutyW-1:0] CEIL_TOP   = 8'd255;
    localparam logic [CountW-1:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [CountW-1:0]  timeout_ticks;
        logic [CountW-1:0]  period_ticks;
        logic [CountW-1:0]  spike_allowance;
        logic [SampleW-1:0] current_limit;
    } mclr_cfg_t;

    typedef struct packed {
        logic [DirW-1:0]   commanded_direction;
        logic [DutyW-1:0]  commanded_duty;
        logic [CountW-1:0] ticks_since_command;
        logic [CountW-1:0] period_count;
        logic [CountW-1:0] overspike_count;
        logic              ramping_down;
        logic              ramping_up;
        logic [DutyW-1:0]  ramp_up_ceiling;
        logic [DutyW-1:0]  ramp_down_ceiling;
        logic [DriveW-1:0] limited_drive;
        logic [DutyW-1:0]  applied_magnitude;
        logic [DirW-1:0]   applied_direction;
    } mclr_state_t;

    // Limiter state after reset: everything clear, ramp-down ceiling at the top
    localparam mclr_state_t STATE_RESET = '{ramp_down_ceiling: CEIL_TOP, default: '0};

    typedef struct packed {
        logic              cmd;
        logic [SampleW-1:0] current_sample;
        logic [DirW-1:0]   new_direction;
        logic [DutyW-1:0]  new_duty;
    } mclr_req_t;

    typedef struct packed {
        logic [DutyW-1:0] drive_magnitude;
        logic [DirW-1:0]  drive_direction;
        logic             ramp_up_active;
        logic             ramp_down_active;
    } mclr_res_t;

    // Counter increment that stops at the top value
    function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
        logic [CountW-1:0] r;
        r = (v != COUNT_MAX) ? v + 16'd1 : COUNT_MAX;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/mclr_req_if.sv
`default_nettype none

interface mclr_req_if
    import mclr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [SampleW-1:0] current_sample;
    logic [DirW-1:0]    new_direction;
    logic [DutyW-1:0]   new_duty;

    modport source (output valid, cmd, current_sample, new_direction, new_duty,
                    input ready);
    modport sink (input valid, cmd, current_sample, new_direction, new_duty,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/mclr_res_if.sv
`default_nettype none

interface mclr_res_if
    import mclr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [DutyW-1:0] drive_magnitude;
    logic [DirW-1:0]  drive_direction;
    logic             ramp_up_active;
    logic             ramp_down_active;

    modport source (output valid, drive_magnitude, drive_direction, ramp_up_active,
                    ramp_down_active, input ready);
    modport sink (input valid, drive_magnitude, drive_direction, ramp_up_active,
                  ramp_down_active, output ready);
endinterface

`default_nettype wire

FILE: hdl/mclr_step.sv
`default_nettype none

// Next-state and result logic for one request
module mclr_step
    import mclr_pkg::*;
(
    input  mclr_cfg_t   cfg,
    input  mclr_state_t cur,
    input  mclr_req_t   req,
    output mclr_state_t nxt,
    output mclr_res_t   res
);

    always_comb
    begin
        logic signed [DriveW:0] v;
        logic signed [DriveW:0] ceil_s;
        logic signed [DriveW:0] ld;
        logic signed [DriveW:0] prev_ld;
        logic [DriveW:0]        prev_mag;
        logic [DriveW:0]        new_mag;
        logic                   clamp;
        logic [DutyW-1:0]       ceil_v;

        nxt      = cur;
        v        = '0;
        ceil_s   = '0;
        ld       = '0;
        clamp    = 1'b0;
        ceil_v   = '0;
        prev_ld  = {cur.limited_drive[DriveW-1], cur.limited_drive};
        prev_mag = prev_ld[DriveW] ? -prev_ld : prev_ld;
        new_mag  = '0;

        if (req.cmd)
        begin
            // A drive command: store it and restart the timeout
            nxt.commanded_direction = req.new_direction;
            nxt.commanded_duty      = req.new_duty;
            nxt.ticks_since_command = '0;
        end
        else if (cur.commanded_direction == DIR_BRAKE)
        begin
            // Braking passes the duty straight through
            nxt.applied_magnitude = cur.commanded_duty;
            nxt.applied_direction = DIR_BRAKE;
        end
        else
        begin
            // Advance the period and timeout counts
            nxt.period_count        = sat_inc(cur.period_count);
            nxt.ticks_since_command = sat_inc(cur.ticks_since_command);
            if (cfg.timeout_ticks != '0 && nxt.ticks_since_command > cfg.timeout_ticks)
            begin
                nxt.commanded_duty = '0;
            end

            v = {2'b00, nxt.commanded_duty};
            if (cur.commanded_direction == DIR_REVERSE)
            begin
                v = -v;
            end

            // End of period: a finished ramp-down turns into a ramp-up, a ramp-up ends and the overspike count clears
            if (nxt.period_count > cfg.period_ticks)
            begin
                nxt.period_count = '0;
                if (cur.ramping_down)
                begin
                    nxt.ramping_down    = 1'b0;
                    nxt.ramp_up_ceiling = CEIL_FLOOR;
                    nxt.ramping_up      = 1'b1;
                end
                else if (cur.ramping_up)
                begin
                    nxt.ramping_up = 1'b0;
                end
                nxt.overspike_count = '0;
            end

            // Too many overspikes start a ramp-down from the present drive
            if (nxt.overspike_count > cfg.spike_allowance)
            begin
                nxt.ramping_down      = 1'b1;
                nxt.ramp_down_ceiling = prev_mag[DutyW-1:0];
                nxt.ramping_up        = 1'b0;
                nxt.overspike_count   = '0;
                nxt.period_count      = '0;
            end

            if (req.current_sample > cfg.current_limit)
            begin
                nxt.overspike_count = sat_inc(nxt.overspike_count);
            end

            // Step the active ramp ceiling
            if (nxt.ramping_down)
            begin
                if (nxt.ramp_down_ceiling > CEIL_FLOOR)
                begin
                    nxt.ramp_down_ceiling = nxt.ramp_down_ceiling - 8'd1;
                end
                ceil_v = nxt.ramp_down_ceiling;
                clamp  = 1'b1;
            end
            else if (nxt.ramping_up)
            begin
                if (nxt.ramp_up_ceiling < CEIL_TOP)
                begin
                    nxt.ramp_up_ceiling = nxt.ramp_up_ceiling + 8'd1;
                end
                ceil_v = nxt.ramp_up_ceiling;
                clamp  = 1'b1;
            end

            // Limit the drive on the commanded side
            ceil_s = {2'b00, ceil_v};
            ld     = v;
            if (clamp)
            begin
                if (cur.commanded_direction == DIR_FORWARD)
                begin
                    ld = (v < ceil_s) ? v : ceil_s;
                end
                else
                begin
                    ld = (v > -ceil_s) ? v : -ceil_s;
                end
            end

            nxt.limited_drive     = ld[DriveW-1:0];
            new_mag               = ld[DriveW] ? -ld : ld;
            nxt.applied_magnitude = new_mag[DutyW-1:0];
            nxt.applied_direction = (ld > 0) ? DIR_FORWARD : DIR_REVERSE;
        end
    end

    // Result fields follow the updated state
    assign res.drive_magnitude  = nxt.applied_magnitude;
    assign res.drive_direction  = nxt.applied_direction;
    assign res.ramp_up_active   = nxt.ramping_up;
    assign res.ramp_down_active = nxt.ramping_down;

endmodule

`default_nettype wire

FILE: hdl/motor_current_limit_ramp.sv
`default_nettype none

// Motor current limiter with overcurrent ramp-down and recovery ramp-up. Each request is
// either a drive command (cmd high) or a control tick carrying one current sample, and
// every request yields exactly one result. A request is captured in an input register and
// its result is formed from it into an output register, so the block takes one request per
// clock cycle while the result side keeps res.ready high. Settings are written through
// cfg_we, cfg_index and cfg_wdata; the user must write them only while no request is in
// flight, and the block itself does not enforce this.
module motor_current_limit_ramp
    import mclr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    mclr_req_if.sink                 req,
    mclr_res_if.source               res,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CountW-1:0]   cfg_wdata
);

    mclr_cfg_t   cfg_reg;
    mclr_state_t state_reg;
    mclr_state_t state_next;
    mclr_req_t   in_reg;
    logic        in_valid_reg;
    mclr_res_t   out_reg;
    mclr_res_t   out_next;
    logic        out_valid_reg;
    logic        advance;

    // Pipeline flow: the input stage moves on when the output register is free
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || advance;

    // Settings registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks   <= TIMEOUT_RESET;
            cfg_reg.period_ticks    <= PERIOD_RESET;
            cfg_reg.spike_allowance <= OVERSPK_RESET;
            cfg_reg.current_limit   <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT_TICKS:   cfg_reg.timeout_ticks   <= cfg_wdata;
                CFG_PERIOD_TICKS:    cfg_reg.period_ticks    <= cfg_wdata;
                CFG_SPIKE_ALLOWANCE: cfg_reg.spike_allowance <= cfg_wdata;
                CFG_CURRENT_LIMIT:   cfg_reg.current_limit   <= cfg_wdata[SampleW-1:0];
                default:             cfg_reg.timeout_ticks   <= cfg_reg.timeout_ticks;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_reg.cmd            <= req.cmd;
            in_reg.current_sample <= req.current_sample;
            in_reg.new_direction  <= req.new_direction;
            in_reg.new_duty       <= req.new_duty;
        end
    end

    // Limiter logic for the request in the input register
    mclr_step u_step (
        .cfg (cfg_reg),
        .cur (state_reg),
        .req (in_reg),
        .nxt (state_next),
        .res (out_next)
    );

    // Limiter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || res.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.drive_magnitude  = out_reg.drive_magnitude;
    assign res.drive_direction  = out_reg.drive_direction;
    assign res.ramp_up_active   = out_reg.ramp_up_active;
    assign res.ramp_down_active = out_reg.ramp_down_active;

endmodule

`default_nettype wire

FILE: dv/mclr_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the settings port, predicts every result of the
// current limiter and compares each accepted result with the oldest prediction.
module mclr_checker
    import mclr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    mclr_req_if                     req,
    mclr_res_if                     res,
    input  wire logic               cfg_we,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [CountW-1:0]  cfg_wdata,
    output int                      fail_count,
    output int                      outstanding
);

    // Settings as the block should hold them.
    logic [CountW-1:0]  timeout_set;
    logic [CountW-1:0]  period_set;
    logic [CountW-1:0]  spike_set;
    logic [SampleW-1:0] limit_set;

    // Predicted limiter state.
    logic [DirW-1:0]    want_dir;
    logic [DutyW-1:0]   want_duty;
    logic [CountW-1:0]  idle_ticks;
    logic [CountW-1:0]  period_ticks_seen;
    logic [CountW-1:0]  spike_count;
    logic               ramp_dn;
    logic               ramp_up;
    logic [DutyW-1:0]   up_ceil;
    logic [DutyW-1:0]   dn_ceil;
    int                 drive_level;
    logic [DutyW-1:0]   out_mag;
    logic [DirW-1:0]    out_dir;

    // Predicted drive results, oldest first.
    mclr_res_t expected_drive_q[$];

    // Counters stop at their top value.
    function automatic logic [CountW-1:0] bump_count(input logic [CountW-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [DutyW-1:0] magnitude_of(input int v);
        int a;
        a = (v < 0) ? -v : v;
        return DutyW'(a);
    endfunction

    // Forward drive is capped from above; every other direction is capped on
    // the reverse side, so a positive drive in direction three passes untouched.
    function automatic int ceiling_clamp(input int v, input logic [DutyW-1:0] c,
                                         input logic [DirW-1:0] d);
        int ci;
        ci = int'(c);
        if (d == DIR_FORWARD)
            return (v < ci) ? v : ci;
        return (v > -ci) ? v : -ci;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0d ns: %s", $time, msg);
        fail_count++;
    endtask

    // Advances the predicted state by one request and returns the drive result.
    task automatic limit_drive_step(input mclr_req_t r, output mclr_res_t o);
        int signed_cmd;
        if (r.cmd)
        begin
            want_dir   = r.new_direction;
            want_duty  = r.new_duty;
            idle_ticks = '0;
        end
        else if (want_dir == DIR_BRAKE)
        begin
            out_mag = want_duty;
            out_dir = DIR_BRAKE;
        end
        else
        begin
            period_ticks_seen = bump_count(period_ticks_seen);
            idle_ticks        = bump_count(idle_ticks);
            if (timeout_set != 0 && idle_ticks > timeout_set)
                want_duty = '0;

            signed_cmd = (want_dir == DIR_REVERSE) ? -int'(want_duty) : int'(want_duty);

            // End of the counting period: a ramp-down turns into a ramp-up,
            // and a finished ramp-up is dropped.
            if (period_ticks_seen > period_set)
            begin
                period_ticks_seen = '0;
                if (ramp_dn)
                begin
                    ramp_dn = 1'b0;
                    up_ceil = CEIL_FLOOR;
                    ramp_up = 1'b1;
                end
                else if (ramp_up)
                    ramp_up = 1'b0;
                spike_count = '0;
            end

            // Too many over-limit samples start a ramp-down from the present drive.
            if (spike_count > spike_set)
            begin
                ramp_dn           = 1'b1;
                dn_ceil           = magnitude_of(drive_level);
                ramp_up           = 1'b0;
                spike_count       = '0;
                period_ticks_seen = '0;
            end

            if (r.current_sample > limit_set)
                spike_count = bump_count(spike_count);

            if (ramp_dn)
            begin
                if (dn_ceil > CEIL_FLOOR)
                    dn_ceil = dn_ceil - 1'b1;
                drive_level = ceiling_clamp(signed_cmd, dn_ceil, want_dir);
            end
            else if (ramp_up)
            begin
                if (up_ceil < CEIL_TOP)
                    up_ceil = up_ceil + 1'b1;
                drive_level = ceiling_clamp(signed_cmd, up_ceil, want_dir);
            end
            else
                drive_level = signed_cmd;

            out_mag = magnitude_of(drive_level);
            out_dir = (drive_level > 0) ? DIR_FORWARD : DIR_REVERSE;
        end

        o.drive_magnitude  = out_mag;
        o.drive_direction  = out_dir;
        o.ramp_up_active   = ramp_up;
        o.ramp_down_active = ramp_dn;
    endtask

    // Settings writes, request prediction and result comparison.
    always @(posedge clk or negedge rst_n)
    begin : watch
        mclr_req_t taken;
        mclr_res_t got;
        mclr_res_t want;
        if (!rst_n)
        begin
            timeout_set       = TIMEOUT_RESET;
            period_set        = PERIOD_RESET;
            spike_set         = OVERSPK_RESET;
            limit_set         = LIMIT_RESET;
            want_dir          = DIR_REVERSE;
            want_duty         = '0;
            idle_ticks        = '0;
            period_ticks_seen = '0;
            spike_count       = '0;
            ramp_dn           = 1'b0;
            ramp_up           = 1'b0;
            up_ceil           = '0;
            dn_ceil           = CEIL_TOP;
            drive_level       = 0;
            out_mag           = '0;
            out_dir           = DIR_REVERSE;
            expected_drive_q.delete();
            outstanding       = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TIMEOUT_TICKS:   timeout_set = cfg_wdata;
                    CFG_PERIOD_TICKS:    period_set  = cfg_wdata;
                    CFG_SPIKE_ALLOWANCE: spike_set   = cfg_wdata;
                    CFG_CURRENT_LIMIT:   limit_set   = cfg_wdata[SampleW-1:0];
                    default: ;
                endcase
            end

            if (req.valid && req.ready)
            begin
                taken.cmd            = req.cmd;
                taken.current_sample = req.current_sample;
                taken.new_direction  = req.new_direction;
                taken.new_duty       = req.new_duty;
                limit_drive_step(taken, want);
                expected_drive_q.push_back(want);
            end

            if (res.valid && res.ready)
            begin
                got.drive_magnitude  = res.drive_magnitude;
                got.drive_direction  = res.drive_direction;
                got.ramp_up_active   = res.ramp_up_active;
                got.ramp_down_active = res.ramp_down_active;
                if (expected_drive_q.size() == 0)
                    report_mismatch($sformatf("result with no request pending: mag %0d dir %0d",
                                              got.drive_magnitude, got.drive_direction));
                else
                begin
                    want = expected_drive_q.pop_front();
                    if (got.drive_magnitude !== want.drive_magnitude)
                        report_mismatch($sformatf("drive_magnitude %0d, expected %0d",
                                                  got.drive_magnitude, want.drive_magnitude));
                    if (got.drive_direction !== want.drive_direction)
                        report_mismatch($sformatf("drive_direction %0d, expected %0d",
                                                  got.drive_direction, want.drive_direction));
                    if (got.ramp_up_active !== want.ramp_up_active)
                        report_mismatch($sformatf("ramp_up_active %0b, expected %0b",
                                                  got.ramp_up_active, want.ramp_up_active));
                    if (got.ramp_down_active !== want.ramp_down_active)
                        report_mismatch($sformatf("ramp_down_active %0b, expected %0b",
                                                  got.ramp_down_active, want.ramp_down_active));
                end
            end

            outstanding = expected_drive_q.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

// Drives commands and current-sample ticks into the limiter, writes its
// settings between phases and gives the verdict from the checker's count.
module tb_top;
    import mclr_pkg::*;

    // Direction three has no name of its own in the block.
    localparam logic [DirW-1:0] DIR_SPARE = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CountW-1:0]  cfg_wdata;
    int                 fail_count;
    int                 outstanding;

    // Flow control shared with the receiver process.
    bit calm;
    bit hold_start;
    int hold_left;

    mclr_req_if req_ch ();
    mclr_res_if res_ch ();

    motor_current_limit_ramp u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    mclr_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .res         (res_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random stalls, a long hold-off on request, none while calm.
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_start)
            begin
                hold_start = 1'b0;
                hold_left  = 300;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= calm || ($urandom_range(99) >= 38);
        end
    end

    // Offers one request, with random gaps first, and returns at the falling
    // edge after it has been taken.
    task automatic send_item(input mclr_req_t item);
        while (!calm && $urandom_range(99) < 38)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.cmd            <= item.cmd;
        req_ch.current_sample <= item.current_sample;
        req_ch.new_direction  <= item.new_direction;
        req_ch.new_duty       <= item.new_duty;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic settle_outputs();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    task automatic load_limits(input logic [CountW-1:0] tmo, input logic [CountW-1:0] per,
                               input logic [CountW-1:0] spk, input logic [CountW-1:0] lim);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TIMEOUT_TICKS;
        cfg_wdata <= tmo;
        @(negedge clk);
        cfg_index <= CFG_PERIOD_TICKS;
        cfg_wdata <= per;
        @(negedge clk);
        cfg_index <= CFG_SPIKE_ALLOWANCE;
        cfg_wdata <= spk;
        @(negedge clk);
        cfg_index <= CFG_CURRENT_LIMIT;
        cfg_wdata <= lim;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Command request; the unused sample carries random noise.
    function automatic mclr_req_t drive_cmd(input logic [DirW-1:0] dir,
                                            input logic [DutyW-1:0] duty);
        mclr_req_t it;
        it.cmd            = 1'b1;
        it.current_sample = SampleW'($urandom_range(1023));
        it.new_direction  = dir;
        it.new_duty       = duty;
        return it;
    endfunction

    // Tick request; the unused command fields carry random noise.
    function automatic mclr_req_t tick(input logic [SampleW-1:0] sample);
        mclr_req_t it;
        it.cmd            = 1'b0;
        it.current_sample = sample;
        it.new_direction  = DirW'($urandom_range(3));
        it.new_duty       = DutyW'($urandom_range(255));
        return it;
    endfunction

    // Mostly ticks with samples clustered either side of the limit, and now
    // and then a command with a random direction and a duty often at an extreme.
    function automatic mclr_req_t random_item(input logic [SampleW-1:0] lim);
        mclr_req_t it;
        int        pick;
        logic [DirW-1:0]  dir;
        logic [DutyW-1:0] duty;
        pick = $urandom_range(99);
        if (pick < 40)
            dir = DIR_FORWARD;
        else if (pick < 75)
            dir = DIR_REVERSE;
        else if (pick < 90)
            dir = DIR_BRAKE;
        else
            dir = DIR_SPARE;
        pick = $urandom_range(99);
        if (pick < 15)
            duty = '0;
        else if (pick < 30)
            duty = '1;
        else
            duty = DutyW'($urandom_range(255));
        if ($urandom_range(99) < 12)
            return drive_cmd(dir, duty);
        pick = $urandom_range(99);
        if (pick < 45 && lim < 10'd1023)
            it = tick(SampleW'($urandom_range(1023, int'(lim) + 1)));
        else if (pick < 85)
            it = tick(SampleW'($urandom_range(int'(lim), 0)));
        else
            it = tick(SampleW'($urandom_range(1023)));
        return it;
    endfunction

    // Stimulus: directed cases, random phases under varied settings, then a
    // calm run with no idling on either side.
    initial
    begin : stimulus
        logic [CountW-1:0]  tmo;
        logic [CountW-1:0]  per;
        logic [CountW-1:0]  spk;
        logic [SampleW-1:0] lim;
        int                 phase;
        int                 n;

        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_TIMEOUT_TICKS;
        cfg_wdata             = '0;
        req_ch.valid          = 1'b0;
        req_ch.cmd            = 1'b0;
        req_ch.current_sample = '0;
        req_ch.new_direction  = DIR_REVERSE;
        req_ch.new_duty       = '0;
        calm                  = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes of every field, each direction, brake pass-through,
        // a sample exactly at the limit and just above it.
        send_item(tick(10'd0));
        send_item(tick(10'd1023));
        send_item(drive_cmd(DIR_FORWARD, 8'd255));
        send_item(tick(10'd1023));
        send_item(tick(10'd200));
        send_item(tick(10'd201));
        send_item(drive_cmd(DIR_REVERSE, 8'd255));
        send_item(tick(10'd0));
        send_item(drive_cmd(DIR_REVERSE, 8'd0));
        send_item(tick(10'd512));
        send_item(drive_cmd(DIR_BRAKE, 8'd255));
        send_item(tick(10'd1023));
        send_item(drive_cmd(DIR_BRAKE, 8'd0));
        send_item(tick(10'd0));
        send_item(drive_cmd(DIR_SPARE, 8'd128));
        send_item(tick(10'd300));
        send_item(drive_cmd(DIR_FORWARD, 8'd1));
        send_item(tick(10'd1));

        // Tight settings: quick timeout, short period, ramp-down after one spike.
        settle_outputs();
        load_limits(16'd1, 16'd2, 16'd0, 16'd0);
        send_item(drive_cmd(DIR_FORWARD, 8'd200));
        repeat (6) send_item(tick(10'd1023));

        // Random phases, the first two at the extremes of every setting.
        for (phase = 0; phase < 8; phase++)
        begin
            settle_outputs();
            if (phase == 0)
            begin
                tmo = '0;
                per = '0;
                spk = '0;
                lim = '0;
                load_limits(tmo, per, spk, 16'd0);
            end
            else if (phase == 1)
            begin
                tmo = '1;
                per = '1;
                spk = '1;
                lim = '1;
                load_limits(tmo, per, spk, 16'hFFFF);
            end
            else
            begin
                tmo = CountW'($urandom_range(40));
                per = CountW'($urandom_range(60));
                spk = CountW'($urandom_range(12));
                lim = SampleW'($urandom_range(1023));
                load_limits(tmo, per, spk, {6'($urandom_range(63)), lim});
            end
            if (phase == 3)
                hold_start = 1'b1;
            for (n = 0; n < 220; n++)
                send_item(random_item(lim));
        end

        // Calm run: requests back to back and the result side always ready.
        calm = 1'b1;
        settle_outputs();
        load_limits(16'd60, 16'd30, 16'd3, 16'd300);
        send_item(drive_cmd(DIR_FORWARD, 8'd255));
        for (n = 0; n < 164; n++)
            send_item(random_item(10'd300));
        calm = 1'b0;

        settle_outputs();
        repeat (10) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
hdl/mclr_pkg.sv
hdl/mclr_req_if.sv
hdl/mclr_res_if.sv
hdl/mclr_step.sv
hdl/motor_current_limit_ramp.sv
dv/mclr_checker.sv
dv/tb_top.sv
